// ===== src/integer_to_radix_digits_defines.svh =====
// ---------------------------------------------------------------------------
// Integer to radix digits: assertion macros
// Shared assertion forms for the conversion block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// implication checked every clock, idle in reset
`define ITRD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// next-cycle implication
`define ITRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

// ===== src/itrd_pkg.sv =====
// ---------------------------------------------------------------------------
// Integer to radix digits: package
// Shared widths, constants, types and digit-to-ASCII function.
// ---------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int DIGIT_STORE = 64;
    localparam int CNT_W       = $clog2(DIGIT_STORE + 1);
    localparam int IDX_W       = $clog2(DIGIT_STORE);
    localparam int DIG_W       = 6;
    localparam int QDEPTH      = 2;

    localparam logic [0:0] REG_RADIX = 1'd0;
    localparam logic [0:0] REG_UBITS = 1'd1;

    localparam logic [5:0] RADIX_DEFAULT = 6'd10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic                  umode;
        logic [2:0]            ubits;
        logic [5:0]            radix;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] r;
        if (d < DIG_W'(10))
            r = 8'h30 + {2'b00, d};
        else
            r = 8'h61 + {2'b00, d} - 8'd10;
        return r;
    endfunction

endpackage

// ===== src/itrd_front.sv =====
// ---------------------------------------------------------------------------
// Integer to radix digits: front end
// Accepts items, resolves mode, radix and magnitude, queues jobs.
// ---------------------------------------------------------------------------
module itrd_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [itrd_pkg::VALUE_BITS-1:0] value,
    input  logic [5:0]                             radix_cfg,
    input  logic [2:0]                             ubits_cfg,
    output logic                                   job_valid,
    output itrd_pkg::job_t                         job,
    input  logic                                   job_take
);

    itrd_pkg::job_t q_reg [itrd_pkg::QDEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    itrd_pkg::job_t in_job;
    logic           do_push, do_pop;
    logic [itrd_pkg::VALUE_BITS-1:0] v;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = job_take && job_valid;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    always_comb
    begin
        v = value;
        in_job.umode = (ubits_cfg != 3'd0);
        in_job.ubits = (ubits_cfg > 3'd5) ? 3'd5 : ubits_cfg;
        in_job.radix = (radix_cfg < 6'd2 || radix_cfg > 6'd36)
                       ? itrd_pkg::RADIX_DEFAULT : radix_cfg;
        in_job.neg   = !in_job.umode && v[itrd_pkg::VALUE_BITS-1];
        in_job.mag   = in_job.neg ? (~v + 1'b1) : v;
    end

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/itrd_back.sv =====
// ---------------------------------------------------------------------------
// Integer to radix digits: back end
// Restoring division per digit (bit-field shift in bit mode), digit memory, reversed readout.
// ---------------------------------------------------------------------------
`include "integer_to_radix_digits_defines.svh"

module itrd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  itrd_pkg::job_t       job,
    output logic                 job_take,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           character,
    output logic                 negative,
    output logic                 last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;
    localparam int VB = itrd_pkg::VALUE_BITS;
    localparam int SW = $clog2(VB);

    logic [1:0]   st_reg, st_next;
    logic [VB-1:0] quo_reg, quo_next;
    logic [5:0]   rem_reg, rem_next;
    logic [SW-1:0] bit_reg, bit_next;
    logic [itrd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]   radix_reg;
    logic         umode_reg;
    logic [2:0]   ubits_reg;
    logic         neg_reg;
    logic [itrd_pkg::DIG_W-1:0] mem [itrd_pkg::DIGIT_STORE];
    logic [itrd_pkg::DIG_W-1:0] rd_reg;
    logic         wr_en;
    logic [itrd_pkg::DIG_W-1:0] wr_d;
    logic [6:0]   trial;
    logic [5:0]   umask;
    logic         rd_en;
    logic         out_valid_reg, out_valid_next;
    logic         last_reg, last_next;

    assign job_take = (st_reg == S_IDLE) && job_valid;
    assign empty    = !out_valid_reg;
    assign character = itrd_pkg::digit_char(rd_reg);
    assign negative  = neg_reg;
    assign last      = last_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[bit_reg]} - {1'b0, radix_reg};
        umask = 6'((7'd1 << ubits_reg) - 7'd1);
        st_next   = st_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        wr_en     = 1'b0;
        wr_d      = '0;
        rd_en     = 1'b0;
        out_valid_next = out_valid_reg;
        last_next = last_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    quo_next = job.mag;
                    rem_next = '0;
                    bit_next = SW'(VB - 1);
                    cnt_next = '0;
                    st_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (umode_reg)
                begin
                    wr_en    = 1'b1;
                    wr_d     = quo_reg[5:0] & umask;
                    quo_next = quo_reg >> ubits_reg;
                    cnt_next = cnt_reg + 1'b1;
                    if (quo_next == '0 || cnt_next == itrd_pkg::CNT_W'(itrd_pkg::DIGIT_STORE))
                        st_next = S_READ;
                end
                else
                begin
                    if (!trial[6])
                    begin
                        rem_next = trial[5:0];
                        quo_next[bit_reg] = 1'b1;
                    end
                    else
                    begin
                        rem_next = {rem_reg[4:0], quo_reg[bit_reg]};
                        quo_next[bit_reg] = 1'b0;
                    end
                    bit_next = bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        wr_en    = 1'b1;
                        wr_d     = rem_next;
                        cnt_next = cnt_reg + 1'b1;
                        rem_next = '0;
                        bit_next = SW'(VB - 1);
                        if (quo_next == '0
                            || cnt_next == itrd_pkg::CNT_W'(itrd_pkg::DIGIT_STORE))
                            st_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                last_next = (cnt_reg == itrd_pkg::CNT_W'(1));
                out_valid_next = 1'b1;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b0;
                    st_next = last_reg ? S_IDLE : S_READ;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[itrd_pkg::IDX_W-1:0]] <= wr_d;
        if (rd_en)
            rd_reg <= mem[cnt_next[itrd_pkg::IDX_W-1:0]];
        if (job_take)
        begin
            radix_reg <= job.radix;
            umode_reg <= job.umode;
            ubits_reg <= job.ubits;
            neg_reg   <= job.neg;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ITRD_ASSERT_IMP(a_out_in_out_state, !empty, st_reg == S_OUT)
    `ITRD_ASSERT_IMP(a_take_only_idle, job_take, st_reg == S_IDLE)
    `ITRD_ASSERT_NEXT(a_last_to_idle, (st_reg == S_OUT) && pop && last_reg, st_reg == S_IDLE)
    `ITRD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= itrd_pkg::CNT_W'(itrd_pkg::DIGIT_STORE))

endmodule

// ===== src/integer_to_radix_digits.sv =====
// Flow: a job waits in the job queue and is loaded by the back end; each digit is divided out
// in radix mode (one quotient bit a cycle) or shifted out in bit mode, then read back and emitted.
// Throughput: one item at a time in the back end; a 2-entry job queue lets the front accept ahead.
// Reset: rst_n asynchronous active low; radix resets to 10, digit bits to 0, queues empty.
// ---------------------------------------------------------------------------
// Integer to radix digits: top level
// Configuration registers, front end and back end.
// ---------------------------------------------------------------------------
module integer_to_radix_digits (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [itrd_pkg::VALUE_BITS-1:0] value,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [7:0]                             character,
    output logic                                   negative,
    output logic                                   last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [0:0]                             cfg_index,
    input  logic [7:0]                             cfg_data
);

    logic [5:0]     radix_reg;
    logic [2:0]     ubits_reg;
    logic           job_valid, job_take;
    itrd_pkg::job_t job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrd_pkg::RADIX_DEFAULT;
            ubits_reg <= 3'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                itrd_pkg::REG_RADIX: radix_reg <= cfg_data[5:0];
                itrd_pkg::REG_UBITS: ubits_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    itrd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .value(value),
        .radix_cfg(radix_reg), .ubits_cfg(ubits_reg),
        .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    itrd_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_take(job_take), .empty(empty), .pop(pop),
        .character(character), .negative(negative), .last(last)
    );

endmodule
